[sv/kde_pkg.sv]
// ----------------------------------------------------------------------------
// kde_pkg - shared types and constants for keypad decimal entry
// Key actions, operator codes, field widths and the key decode function.
// ----------------------------------------------------------------------------
package kde_pkg;

  localparam int unsigned MaxDigitsDef = 9;   // default digit store depth
  localparam int unsigned KeyW         = 16;  // keypad snapshot width
  localparam int unsigned DigitW       = 4;   // one bcd digit
  localparam int unsigned CountW       = 4;   // digit count
  localparam int unsigned ValueW       = 30;  // nine decimal digits fit in 30 bits
  localparam int unsigned OpW          = 3;
  localparam int unsigned HighW        = 14;
  localparam int unsigned LowW         = 16;
  localparam int unsigned ShownDigits  = 9;
  localparam int unsigned ShownW       = ShownDigits * DigitW;
  localparam int unsigned InDataW      = 16;
  localparam int unsigned OutFieldsW   = OpW + HighW + LowW + ShownW + CountW;
  localparam int unsigned OutDataW     = ((OutFieldsW + 7) / 8) * 8;
  localparam int unsigned FifoDepth    = 2;

  // output tdata bit positions, lowest field first
  localparam int unsigned OpLsb     = 0;
  localparam int unsigned HighLsb   = OpLsb + OpW;
  localparam int unsigned LowLsb    = HighLsb + HighW;
  localparam int unsigned ShownLsb  = LowLsb + LowW;
  localparam int unsigned LengthLsb = ShownLsb + ShownW;

  typedef enum logic [1:0] {
    ACT_DIGIT,
    ACT_BACKSPACE,
    ACT_OPER
  } act_kind_t;

  typedef struct packed {
    act_kind_t         kind;
    logic [DigitW-1:0] code;   // digit value or operator code
  } action_t;

  localparam logic [DigitW-1:0] OP_DIVIDE   = 4'd0;
  localparam logic [DigitW-1:0] OP_MULTIPLY = 4'd1;
  localparam logic [DigitW-1:0] OP_SUBTRACT = 4'd2;
  localparam logic [DigitW-1:0] OP_EQUALS   = 4'd3;
  localparam logic [DigitW-1:0] OP_ADD      = 4'd4;

  // per key index (row*4 + column)
  localparam action_t KeyAction [16] = '{
    '{ACT_DIGIT, 4'd7}, '{ACT_DIGIT, 4'd8}, '{ACT_DIGIT, 4'd9}, '{ACT_OPER, OP_DIVIDE},
    '{ACT_DIGIT, 4'd4}, '{ACT_DIGIT, 4'd5}, '{ACT_DIGIT, 4'd6}, '{ACT_OPER, OP_MULTIPLY},
    '{ACT_DIGIT, 4'd1}, '{ACT_DIGIT, 4'd2}, '{ACT_DIGIT, 4'd3}, '{ACT_OPER, OP_SUBTRACT},
    '{ACT_BACKSPACE, 4'd0}, '{ACT_DIGIT, 4'd0}, '{ACT_OPER, OP_EQUALS}, '{ACT_OPER, OP_ADD}
  };

  // lowest pressed row within the highest pressed column
  function automatic logic [3:0] choose_key(input logic [KeyW-1:0] keys);
    logic [1:0] col;
    logic [1:0] row;
    col = '0;
    row = '0;
    for (int c = 0; c < 4; c++) begin
      if (keys[c] || keys[4 + c] || keys[8 + c] || keys[12 + c]) col = 2'(c);
    end
    for (int r = 3; r >= 0; r--) begin
      if (keys[{2'(r), col}]) row = 2'(r);
    end
    return {row, col};
  endfunction

endpackage

[sv/keypad_decimal_entry.sv]
// ----------------------------------------------------------------------------
// keypad_decimal_entry - decimal number entry from 4x4 keypad snapshots
// Turns keypad snapshots into digit edits and operator sends.
// ----------------------------------------------------------------------------
// usage:
//   s_* channel: one 16-bit keypad snapshot per transaction, bit row*4+column
//   set for each pressed key. an all-zero snapshot is taken and gives nothing.
//   m_* channel: one result per non-empty snapshot. m_tuser flags an operator
//   send; m_tdata carries op code, the 30-bit value split high/low, the nine
//   shown bcd digits (first digit lowest) and the digit count.
//   throughput: one snapshot per cycle while results are taken; the back end
//   updates the digit store and the running binary value for each key.
//   result path: the action queue is written at the accepting edge, and the
//   result register is loaded when the back end pops that action, once the
//   result side is free.
//   the running value is kept alongside the digits, with per-position prefix
//   values so that backspace needs no division.
//   reset: synchronous, clears the digit count, value, queue and result valid.
//   stall: a held result keeps m_tdata steady; the two-entry queue absorbs
//   input until full, then s_tready drops while the result stays held.
// ----------------------------------------------------------------------------
module keypad_decimal_entry #(
  parameter int unsigned MAX_DIGITS = kde_pkg::MaxDigitsDef
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [kde_pkg::InDataW-1:0]  s_tdata,   // [15:0] pressed_keys
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [2:0] op_code, [16:3] value_high, [32:17] value_low,
  // [68:33] shown_digits, [72:69] shown_length, [79:73] zero
  output logic [kde_pkg::OutDataW-1:0] m_tdata,
  output logic                         m_tuser    // [0] send_valid
);
  import kde_pkg::*;

  // front to queue
  logic    push_valid;
  logic    push_ready;
  action_t push_action;
  // queue to back
  logic    pop_valid;
  logic    pop_ready;
  action_t pop_action;

  // decode the snapshot into one action
  kde_front u_front (
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_action (push_action)
  );

  // lets intake and result delivery stall independently
  kde_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_action (push_action),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_action  (pop_action)
  );

  // digit store, value tracking and the result register
  kde_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_action (pop_action),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

[sv/kde_front.sv]
// ----------------------------------------------------------------------------
// kde_front - snapshot intake and key classification
// Drops empty snapshots, picks the active key and pushes its action.
// ----------------------------------------------------------------------------
module kde_front (
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [kde_pkg::InDataW-1:0] s_tdata,   // [15:0] pressed_keys
  output logic                       push_valid,
  input  logic                       push_ready,
  output kde_pkg::action_t           push_action
);
  import kde_pkg::*;

  assign s_tready    = push_ready;
  // an empty snapshot is taken but makes no action
  assign push_valid  = s_tvalid && (s_tdata != '0);
  assign push_action = KeyAction[choose_key(s_tdata)];

endmodule

[sv/kde_queue.sv]
// ----------------------------------------------------------------------------
// kde_queue - short action queue between front and back
// Register-based fifo, push and pop in the same cycle when full.
// ----------------------------------------------------------------------------
module kde_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  kde_pkg::action_t push_action,
  output logic             pop_valid,
  input  logic             pop_ready,
  output kde_pkg::action_t pop_action
);
  import kde_pkg::*;

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  action_t         slots [FifoDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;
  logic            do_push;
  logic            do_pop;

  assign do_pop     = pop_valid && pop_ready;
  assign push_ready = (fill != CntW'(FifoDepth)) || pop_ready;
  assign do_push    = push_valid && push_ready;
  assign pop_valid  = (fill != '0);
  assign pop_action = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_action;
    end
  end

endmodule

[sv/kde_back.sv]
// ----------------------------------------------------------------------------
// kde_back - digit store, running value and result register
// Applies one action per cycle while the result is free or being taken, and holds the result until taken.
// ----------------------------------------------------------------------------
module kde_back #(
  parameter int unsigned MAX_DIGITS = kde_pkg::MaxDigitsDef
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  kde_pkg::action_t             pop_action,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [kde_pkg::OutDataW-1:0] m_tdata,  // op, high, low, digits, length
  output logic                         m_tuser   // [0] send_valid
);
  import kde_pkg::*;

  localparam int unsigned IdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic [DigitW-1:0] digits      [MAX_DIGITS];
  logic [DigitW-1:0] digits_next [MAX_DIGITS];
  logic [ValueW-1:0] prefix      [MAX_DIGITS];  // value of the digits below each entry
  logic [CountW-1:0] count;
  logic [CountW-1:0] count_next;
  logic [ValueW-1:0] value;
  logic [ValueW-1:0] value_next;

  logic              full;
  logic [CountW-1:0] count_dec;
  logic [IdxW-1:0]   last_idx;
  logic [IdxW-1:0]   tail_idx;
  logic [ValueW-1:0] prefix_rd;
  logic [ValueW-1:0] mul_base;
  logic [ValueW-1:0] times_ten;
  logic              pf_we;
  logic              do_pop;

  logic              send_next;
  logic [OpW-1:0]    op_next;
  logic [ValueW-1:0] sent_next;
  logic [ShownW-1:0] shown_next;

  logic              out_send;
  logic [OpW-1:0]    out_op;
  logic [ValueW-1:0] out_value;
  logic [ShownW-1:0] out_shown;
  logic [CountW-1:0] out_length;

  assign pop_ready = !m_tvalid || m_tready;
  assign do_pop    = pop_valid && pop_ready;

  assign full      = (count >= CountW'(MAX_DIGITS));
  assign count_dec = count - 1'b1;
  assign last_idx  = count_dec[IdxW-1:0];
  assign tail_idx  = count[IdxW-1:0];
  assign prefix_rd = prefix[last_idx];
  // replacing the last digit restarts from the prefix below it
  assign mul_base  = full ? prefix_rd : value;
  assign times_ten = ValueW'({mul_base, 3'b000} + {mul_base, 1'b0}
                             + (ValueW + 3)'(pop_action.code));

  always_comb begin
    digits_next = digits;
    count_next  = count;
    value_next  = value;
    pf_we       = 1'b0;
    send_next   = 1'b0;
    op_next     = '0;
    sent_next   = '0;
    case (pop_action.kind)
      ACT_DIGIT: begin
        value_next = times_ten;
        if (full) begin
          digits_next[MAX_DIGITS-1] = pop_action.code;
        end else begin
          digits_next[tail_idx] = pop_action.code;
          pf_we                 = 1'b1;
          count_next            = count + 1'b1;
        end
      end
      ACT_BACKSPACE: begin
        if (count != '0) begin
          count_next = count_dec;
          value_next = prefix_rd;
        end
      end
      ACT_OPER: begin
        send_next  = 1'b1;
        op_next    = pop_action.code[OpW-1:0];
        sent_next  = value;
        count_next = '0;
        value_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  // digits at or past the count read as zero
  always_comb begin
    shown_next = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (CountW'(i) < count_next) shown_next[DigitW*i +: DigitW] = digits_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      value    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (do_pop) begin
        count    <= count_next;
        value    <= value_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      digits     <= digits_next;
      out_send   <= send_next;
      out_op     <= op_next;
      out_value  <= sent_next;
      out_shown  <= shown_next;
      out_length <= count_next;
      if (pf_we) begin
        prefix[tail_idx] <= value;
      end
    end
  end

  assign m_tuser = out_send;
  assign m_tdata = {(OutDataW - OutFieldsW)'(0), out_length, out_shown,
                    out_value[LowW-1:0], out_value[ValueW-1:LowW], out_op};

endmodule

[sv/kde_checker.sv]
// ----------------------------------------------------------------------------
// kde_checker - port-level checks for keypad decimal entry
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module kde_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [kde_pkg::OutDataW-1:0] m_tdata,
  input logic                         m_tuser
);
  import kde_pkg::*;

  logic [CountW-1:0] shown_len;
  assign shown_len = m_tdata[LengthLsb +: CountW];

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> shown_len <= CountW'(ShownDigits))
    else $error("digit count out of range");

  // a send empties the entry
  a_send_clears: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> shown_len == '0 && m_tdata[ShownLsb +: ShownW] == '0)
    else $error("entry not cleared by send");

  // without a send the op and value fields stay zero
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[ShownLsb-1:0] == '0)
    else $error("value fields set without a send");

endmodule

bind keypad_decimal_entry kde_checker u_kde_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
